### rtl/spq_pkg.sv
`default_nettype none

package spq_pkg;

    localparam int IdWidth = 16;
    localparam int PriWidth = 8;
    localparam int StatusWidth = 2;
    localparam int FillWidth = 5;

    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_DEQUEUE = 1'b1;

    localparam logic [StatusWidth-1:0] STATUS_OK = 2'd0;
    localparam logic [StatusWidth-1:0] STATUS_FULL = 2'd1;
    localparam logic [StatusWidth-1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic load;
        logic exec;
    } spq_cmd_t;

endpackage

`default_nettype wire

### rtl/spq_ctrl.sv
`default_nettype none

module spq_ctrl
    import spq_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  wire logic     out_ready,
    output spq_cmd_t      cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RESP
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_RESP);
    assign cmd.load = in_valid && (state_reg == S_IDLE);
    assign cmd.exec = (state_reg == S_EXEC);

endmodule

`default_nettype wire

### rtl/spq_datapath.sv
`default_nettype none

module spq_datapath
    import spq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire spq_cmd_t               cmd,
    input  wire logic                   op,
    input  wire logic [IdWidth-1:0]     proc_id,
    input  wire logic [PriWidth-1:0]    priority_req,
    output logic [StatusWidth-1:0]      status,
    output logic [IdWidth-1:0]          out_id,
    output logic [PriWidth-1:0]         out_priority,
    output logic [FillWidth-1:0]        fill_count
);

    localparam int CountWidth = $clog2(QUEUE_DEPTH + 1);

    logic                    op_reg;
    logic [IdWidth-1:0]      id_in_reg;
    logic [PriWidth-1:0]     pri_in_reg;

    logic [IdWidth-1:0]      id_reg [QUEUE_DEPTH];
    logic [PriWidth-1:0]     pri_reg [QUEUE_DEPTH];
    logic [IdWidth-1:0]      id_next [QUEUE_DEPTH];
    logic [PriWidth-1:0]     pri_next [QUEUE_DEPTH];
    logic [CountWidth-1:0]   count_reg;
    logic [CountWidth-1:0]   count_next;

    logic [StatusWidth-1:0]  status_reg;
    logic [StatusWidth-1:0]  status_next;
    logic [IdWidth-1:0]      out_id_reg;
    logic [IdWidth-1:0]      out_id_next;
    logic [PriWidth-1:0]     out_pri_reg;
    logic [PriWidth-1:0]     out_pri_next;

    logic                    is_full;
    logic                    is_empty;
    logic                    do_insert;
    logic                    do_remove;
    logic [QUEUE_DEPTH-1:0]  after_mask;
    logic [QUEUE_DEPTH-1:0]  after_prev;

    assign is_full = (count_reg == CountWidth'(QUEUE_DEPTH));
    assign is_empty = (count_reg == '0);
    assign do_insert = cmd.exec && (op_reg == OP_ENQUEUE) && !is_full;
    assign do_remove = cmd.exec && (op_reg == OP_DEQUEUE) && !is_empty;

    // A cell lies after the insertion point when it is empty or holds a
    // strictly larger priority; the mask is monotone because the cells are sorted.
    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            after_mask[i] = (count_reg <= CountWidth'(i)) || (pri_reg[i] > pri_in_reg);
        end
    end

    assign after_prev = {after_mask[QUEUE_DEPTH-2:0], 1'b0};

    for (genvar g = 0; g < QUEUE_DEPTH; g++)
    begin : g_cell
        logic [IdWidth-1:0]  id_up;
        logic [PriWidth-1:0] pri_up;
        logic [IdWidth-1:0]  id_down;
        logic [PriWidth-1:0] pri_down;

        if (g == QUEUE_DEPTH - 1)
        begin : g_last
            assign id_up = id_reg[g];
            assign pri_up = pri_reg[g];
        end
        else
        begin : g_inner
            assign id_up = id_reg[g+1];
            assign pri_up = pri_reg[g+1];
        end

        if (g == 0)
        begin : g_first
            assign id_down = id_reg[g];
            assign pri_down = pri_reg[g];
        end
        else
        begin : g_rest
            assign id_down = id_reg[g-1];
            assign pri_down = pri_reg[g-1];
        end

        always_comb
        begin
            id_next[g] = id_reg[g];
            pri_next[g] = pri_reg[g];
            if (do_insert && after_mask[g] && !after_prev[g])
            begin
                id_next[g] = id_in_reg;
                pri_next[g] = pri_in_reg;
            end
            else if (do_insert && after_mask[g])
            begin
                id_next[g] = id_down;
                pri_next[g] = pri_down;
            end
            else if (do_remove)
            begin
                id_next[g] = id_up;
                pri_next[g] = pri_up;
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        status_next = STATUS_OK;
        out_id_next = '0;
        out_pri_next = '0;
        if (op_reg == OP_ENQUEUE)
        begin
            if (is_full)
            begin
                status_next = STATUS_FULL;
            end
            else
            begin
                count_next = count_reg + CountWidth'(1);
            end
        end
        else
        begin
            if (is_empty)
            begin
                status_next = STATUS_EMPTY;
            end
            else
            begin
                out_id_next = id_reg[0];
                out_pri_next = pri_reg[0];
                count_next = count_reg - CountWidth'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= op;
            id_in_reg <= proc_id;
            pri_in_reg <= priority_req;
        end
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            id_reg[i] <= id_next[i];
            pri_reg[i] <= pri_next[i];
        end
        if (cmd.exec)
        begin
            status_reg <= status_next;
            out_id_reg <= out_id_next;
            out_pri_reg <= out_pri_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.exec)
        begin
            count_reg <= count_next;
        end
    end

    assign status = status_reg;
    assign out_id = out_id_reg;
    assign out_priority = out_pri_reg;
    assign fill_count = FillWidth'(count_reg);

endmodule

`default_nettype wire

### rtl/stable_priority_queue_core.sv
// Stable priority queue of process entries held in a row of sorted cells.
// Input channel (in_valid/in_ready) carries op, proc_id and priority_req:
// an enqueue places the entry after every held entry of lower or equal
// priority, a dequeue removes the head entry.
// Output channel (out_valid/out_ready) returns one item per input item:
// status, out_id and out_priority of a removed entry, and fill_count.
// An item passes through three steps: it is captured, then every cell
// compares and shifts in parallel, then the result is presented. The next
// item is taken once the result has gone, so no new item is taken while
// the previous one is still in progress.
// A stalled receiver holds the result and the queue; no input is taken
// until the result is accepted.
// Reset empties the queue at once; there is no clearing pass.
`default_nettype none

module stable_priority_queue_core
    import spq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic                   op,
    input  wire logic [IdWidth-1:0]     proc_id,
    input  wire logic [PriWidth-1:0]    priority_req,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [StatusWidth-1:0]      status,
    output logic [IdWidth-1:0]          out_id,
    output logic [PriWidth-1:0]         out_priority,
    output logic [FillWidth-1:0]        fill_count
);

    spq_cmd_t cmd;

    spq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    spq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .op           (op),
        .proc_id      (proc_id),
        .priority_req (priority_req),
        .status       (status),
        .out_id       (out_id),
        .out_priority (out_priority),
        .fill_count   (fill_count)
    );

endmodule

`default_nettype wire
